// ===== src/fca_pkg.sv =====
package fca_pkg;

  localparam int NUM_CLUSTERS  = 4096;
  localparam int CLUSTER_BYTES = 512;
  localparam int MAX_CHAIN     = 64;

  localparam int CW       = $clog2(NUM_CLUSTERS);
  localparam int LW       = 13;
  localparam int CNT_W    = 13;
  localparam int NEED_W   = $clog2(MAX_CHAIN + 1);
  localparam int CB_SHIFT = $clog2(CLUSTER_BYTES);

  localparam logic [LW-1:0]    END_MARK   = 13'h1FFF;
  localparam logic [LW-1:0]    NUM_LINK   = LW'(NUM_CLUSTERS);
  localparam logic [CNT_W-1:0] NUM_COUNT  = CNT_W'(NUM_CLUSTERS);
  localparam logic [CW-1:0]    LAST_INDEX = CW'(NUM_CLUSTERS - 1);
  localparam logic [16:0]      CB_ROUND   = 17'(CLUSTER_BYTES - 1);
  localparam logic [19:0]      MAX_BYTES  = 20'(MAX_CHAIN * CLUSTER_BYTES);

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TOO_LARGE  = 2'd2,
    ST_START_FREE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_A_CHECK,
    S_A_NEED,
    S_A_FIT,
    S_A_RD,
    S_A_CHK,
    S_A_END,
    S_F_RD,
    S_F_CHK,
    S_F_CLEAR,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic [11:0]      cluster;
    logic [CNT_W-1:0] count;
    logic             last;
    status_t          status;
  } result_t;

  typedef struct packed {
    logic          we;
    logic [CW-1:0] waddr;
    logic [LW-1:0] wdata;
    logic          re;
    logic [CW-1:0] raddr;
  } tbl_req_t;

endpackage

// ===== src/fca_if.sv =====
interface fca_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] size_bytes;
  logic [11:0] start_cluster;

  modport source (output valid, func, size_bytes, start_cluster, input ready);
  modport sink (input valid, func, size_bytes, start_cluster, output ready);
endinterface

interface fca_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] cluster;
  logic [12:0] count;
  logic        last;
  logic [1:0]  status;

  modport source (output valid, cluster, count, last, status, input ready);
  modport sink (input valid, cluster, count, last, status, output ready);
endinterface

// ===== src/fca_table.sv =====
module fca_table (
  input  logic                clk,
  input  fca_pkg::tbl_req_t   req,
  output logic [fca_pkg::LW-1:0] rdata
);
  import fca_pkg::*;

  logic [LW-1:0] mem [NUM_CLUSTERS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule

// ===== src/fca_out_reg.sv =====
module fca_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             emit,
  input  fca_pkg::result_t res,
  output logic             can_emit,
  fca_rsp_if.source        rsp
);
  import fca_pkg::*;

  logic    valid;
  result_t held;

  assign can_emit = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (emit) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      held <= res;
    end
  end

  assign rsp.valid   = valid;
  assign rsp.cluster = held.cluster;
  assign rsp.count   = held.count;
  assign rsp.last    = held.last;
  assign rsp.status  = held.status;
endmodule

// ===== src/fca_ctrl.sv =====
module fca_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  fca_req_if.sink                req,
  input  logic [fca_pkg::LW-1:0] rdata,
  input  logic                   can_emit,
  output fca_pkg::tbl_req_t      tbl,
  output logic                   emit,
  output fca_pkg::result_t       res
);
  import fca_pkg::*;

  state_t            state, state_next;
  logic [15:0]       rem, rem_next;
  logic [NEED_W-1:0] need, need_next;
  logic [NEED_W-1:0] got, got_next;
  logic [CW-1:0]     cur, cur_next;
  logic [CW-1:0]     prev, prev_next;
  logic [LW-1:0]     nxt, nxt_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  free_cnt, free_cnt_next;
  status_t           rsp_status, rsp_status_next;

  // shared increment and sum logic
  logic [CNT_W:0]    free_sum;
  logic [CNT_W-1:0]  count_inc;
  logic [NEED_W-1:0] got_inc;

  assign count_inc = count + 1'b1;
  assign got_inc   = got + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      cur      <= '0;
      free_cnt <= NUM_COUNT;
    end else begin
      state    <= state_next;
      cur      <= cur_next;
      free_cnt <= free_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    rem        <= rem_next;
    need       <= need_next;
    got        <= got_next;
    prev       <= prev_next;
    nxt        <= nxt_next;
    count      <= count_next;
    rsp_status <= rsp_status_next;
  end

  always_comb begin
    state_next      = state;
    rem_next        = rem;
    need_next       = need;
    got_next        = got;
    cur_next        = cur;
    prev_next       = prev;
    nxt_next        = nxt;
    count_next      = count;
    free_cnt_next   = free_cnt;
    rsp_status_next = rsp_status;
    free_sum        = '0;
    tbl             = '0;
    req.ready       = 1'b0;
    emit            = 1'b0;
    res             = '0;

    unique case (state)
      S_CLR: begin
        tbl.we    = 1'b1;
        tbl.waddr = cur;
        tbl.wdata = '0;
        cur_next  = cur + 1'b1;
        if (cur == LAST_INDEX) begin
          cur_next   = '0;
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          count_next = '0;
          if (req.func == FN_ALLOC) begin
            rem_next   = req.size_bytes;
            state_next = S_A_CHECK;
          end else if ({1'b0, req.start_cluster} >= NUM_LINK) begin
            rsp_status_next = ST_START_FREE;
            state_next      = S_REPLY;
          end else begin
            cur_next   = CW'(req.start_cluster);
            state_next = S_F_RD;
          end
        end
      end

      S_A_CHECK: begin
        need_next = '0;
        if (rem == 16'd0) begin
          rsp_status_next = ST_OK;
          state_next      = S_REPLY;
        end else if ({4'd0, rem} > MAX_BYTES) begin
          rsp_status_next = ST_TOO_LARGE;
          state_next      = S_REPLY;
        end else begin
          state_next = S_A_NEED;
        end
      end

      S_A_NEED: begin
        need_next  = NEED_W'(({1'b0, rem} + CB_ROUND) >> CB_SHIFT);
        state_next = S_A_FIT;
      end

      S_A_FIT: begin
        if (CNT_W'(need) > free_cnt) begin
          rsp_status_next = ST_NO_SPACE;
          state_next      = S_REPLY;
        end else begin
          cur_next   = '0;
          got_next   = '0;
          state_next = S_A_RD;
        end
      end

      S_A_RD: begin
        tbl.re     = 1'b1;
        tbl.raddr  = cur;
        state_next = S_A_CHK;
      end

      S_A_CHK: begin
        if (rdata == '0) begin
          if (can_emit) begin
            emit        = 1'b1;
            res.cluster = 12'(cur);
            res.last    = (got_inc == need);
            res.status  = ST_OK;
            if (got != '0) begin
              tbl.we    = 1'b1;
              tbl.waddr = prev;
              tbl.wdata = LW'(cur);
            end
            prev_next = cur;
            got_next  = got_inc;
            if (got_inc == need || cur == LAST_INDEX) begin
              state_next = S_A_END;
            end else begin
              cur_next   = cur + 1'b1;
              state_next = S_A_RD;
            end
          end
        end else if (cur == LAST_INDEX) begin
          state_next = S_A_END;
        end else begin
          cur_next   = cur + 1'b1;
          state_next = S_A_RD;
        end
      end

      S_A_END: begin
        if (got != '0) begin
          tbl.we    = 1'b1;
          tbl.waddr = prev;
          tbl.wdata = END_MARK;
        end
        free_cnt_next = free_cnt - CNT_W'(got);
        state_next    = S_IDLE;
      end

      S_F_RD: begin
        tbl.re     = 1'b1;
        tbl.raddr  = cur;
        state_next = S_F_CHK;
      end

      S_F_CHK: begin
        if (rdata == '0) begin
          if (count == '0) begin
            rsp_status_next = ST_START_FREE;
          end else begin
            free_sum        = {1'b0, free_cnt} + {1'b0, count};
            free_cnt_next   = (free_sum > {1'b0, NUM_COUNT}) ? NUM_COUNT : free_sum[CNT_W-1:0];
            rsp_status_next = ST_OK;
          end
          state_next = S_REPLY;
        end else begin
          nxt_next   = rdata;
          state_next = S_F_CLEAR;
        end
      end

      S_F_CLEAR: begin
        tbl.we     = 1'b1;
        tbl.waddr  = cur;
        tbl.wdata  = '0;
        count_next = count_inc;
        if (nxt == END_MARK || nxt >= NUM_LINK || count_inc == NUM_COUNT) begin
          free_sum        = {1'b0, free_cnt} + {1'b0, count_inc};
          free_cnt_next   = (free_sum > {1'b0, NUM_COUNT}) ? NUM_COUNT : free_sum[CNT_W-1:0];
          rsp_status_next = ST_OK;
          state_next      = S_REPLY;
        end else begin
          cur_next   = nxt[CW-1:0];
          state_next = S_F_RD;
        end
      end

      S_REPLY: begin
        if (can_emit) begin
          emit       = 1'b1;
          res.count  = count;
          res.last   = 1'b1;
          res.status = rsp_status;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== src/fat_cluster_chain_allocator.sv =====
// cluster chain allocator over a table of 4096 links (0 free, all ones end of chain)
// req channel: func 0 allocates size_bytes rounded up to 512-byte clusters,
//   func 1 frees the chain that starts at start_cluster
// rsp channel: allocate gives one beat per claimed cluster in chain order, last on
//   the final one; zero size, too large or not enough free give a single beat with
//   cluster 0 and the matching status; free gives a single beat with the count
// the block takes one request at a time and holds req.ready low until it is done
// allocate: check, size and fit steps, then a read and a check step per table entry
//   scanned from cluster 0, one table read port
// free: a read, a check and a clear step per cluster on the chain, plus a read and
//   a check of the linked cluster when the chain ends at a link to a free cluster
// reset clears the table in a pass over all 4096 entries, one entry per cycle, with
//   req.ready low
// results sit in an output register; if rsp.ready stays low the sequencer
//   waits on the next beat and the table is left untouched
module fat_cluster_chain_allocator (
  input  logic      clk,
  input  logic      rst,
  fca_req_if.sink   req,
  fca_rsp_if.source rsp
);
  import fca_pkg::*;

  tbl_req_t      tbl;
  logic [LW-1:0] rdata;
  logic          emit;
  logic          can_emit;
  result_t       res;

  fca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rdata    (rdata),
    .can_emit (can_emit),
    .tbl      (tbl),
    .emit     (emit),
    .res      (res)
  );

  fca_table u_table (
    .clk   (clk),
    .req   (tbl),
    .rdata (rdata)
  );

  fca_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .res      (res),
    .can_emit (can_emit),
    .rsp      (rsp)
  );
endmodule

// ===== bench/fat_cluster_chain_allocator_tb.sv =====
module fat_cluster_chain_allocator_tb;
  import fca_pkg::*;

  localparam int WATCH_LIMIT = 60000;
  localparam int TAIL_CYCLES = 40;
  localparam int PRINT_CAP   = 100;

  class chain_board;
    logic [LW-1:0] links [NUM_CLUSTERS];
    int unsigned   free_cnt;
    result_t       due_beats[$];
    int unsigned   heads[$];
    int unsigned   claimed[$];

    function new();
      foreach (links[i]) links[i] = '0;
      free_cnt = NUM_CLUSTERS;
    endfunction

    function void add_due(logic [11:0] c, int unsigned n, logic l, status_t s);
      result_t r;
      r.cluster = c;
      r.count   = CNT_W'(n);
      r.last    = l;
      r.status  = s;
      due_beats = {due_beats, r};
    endfunction

    function void note_request(logic fn, logic [15:0] size, logic [11:0] start);
      int unsigned need, got, prev, cur, nxt, n, c;
      if (fn == FN_ALLOC) begin
        need = (int'(size) + CLUSTER_BYTES - 1) / CLUSTER_BYTES;
        if (need == 0) begin
          add_due('0, 0, 1'b1, ST_OK);
        end else if (need > MAX_CHAIN) begin
          add_due('0, 0, 1'b1, ST_TOO_LARGE);
        end else if (need > free_cnt) begin
          add_due('0, 0, 1'b1, ST_NO_SPACE);
        end else begin
          got  = 0;
          prev = 0;
          for (c = 0; c < NUM_CLUSTERS && got < need; c++) begin
            if (links[c] == '0) begin
              links[c] = END_MARK;
              if (got > 0) links[prev] = LW'(c);
              else heads = {heads, c};
              claimed = {claimed, c};
              add_due(12'(c), 0, (got + 1 == need), ST_OK);
              prev = c;
              got++;
            end
          end
          free_cnt -= got;
        end
      end else begin
        if (links[start] == '0) begin
          add_due('0, 0, 1'b1, ST_START_FREE);
        end else begin
          cur = start;
          n   = 0;
          while (n < NUM_CLUSTERS) begin
            nxt = links[cur];
            links[cur] = '0;
            n++;
            if (nxt == END_MARK || nxt >= NUM_CLUSTERS) break;
            if (links[nxt] == '0) break;
            cur = nxt;
          end
          free_cnt += n;
          if (free_cnt > NUM_CLUSTERS) free_cnt = NUM_CLUSTERS;
          add_due('0, n, 1'b1, ST_OK);
        end
      end
    endfunction

    function bit check_beat(result_t got, output string msg);
      result_t want;
      if (due_beats.size() == 0) begin
        msg = $sformatf("unexpected beat cluster %0d count %0d last %0b status %0d",
                        got.cluster, got.count, got.last, got.status);
        return 1'b0;
      end
      want = due_beats.pop_front();
      if (got.cluster !== want.cluster || got.count !== want.count ||
          got.last !== want.last || got.status !== want.status) begin
        msg = $sformatf("beat cluster %0d count %0d last %0b status %0d, want %0d %0d %0b %0d",
                        got.cluster, got.count, got.last, got.status,
                        want.cluster, want.count, want.last, want.status);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // mostly known chain heads, some inner clusters, some arbitrary ones
    function logic [11:0] pick_start();
      int unsigned r, k;
      r = $urandom_range(0, 99);
      if (r < 60 && heads.size() > 0) begin
        k = $urandom_range(0, heads.size() - 1);
        pick_start = 12'(heads[k]);
        heads.delete(k);
        return pick_start;
      end
      if (r < 85 && claimed.size() > 0) return 12'(claimed[$urandom_range(0, claimed.size() - 1)]);
      return 12'($urandom_range(0, NUM_CLUSTERS - 1));
    endfunction
  endclass

  logic clk;
  logic rst;

  fca_req_if req ();
  fca_rsp_if rsp ();

  fat_cluster_chain_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  chain_board board = new();
  int errors;
  bit calm;
  int hold_len;
  int idle_cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report(string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
  endtask

  task automatic send(logic fn, logic [15:0] size, logic [11:0] start);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid         = 1'b1;
    req.func          = fn;
    req.size_bytes    = size;
    req.start_cluster = start;
    do @(posedge clk); while (req.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid = 1'b0;
    while (board.due_beats.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 45) return 16'($urandom_range(1, 2048));
    if (r < 80) return 16'($urandom_range(2049, 16384));
    if (r < 95) return 16'($urandom_range(16385, 32768));
    return 16'($urandom_range(32769, 65535));
  endfunction

  task automatic send_random(int free_pct);
    if ($urandom_range(0, 99) < free_pct) send(FN_FREE, 16'($urandom), board.pick_start());
    else send(FN_ALLOC, rand_size(), 12'($urandom));
  endtask

  // claim full-length chains, ask for more than is left, fill the rest, then ask for one more
  task automatic fill_table();
    int unsigned n, rem;
    n   = board.free_cnt / MAX_CHAIN;
    rem = board.free_cnt % MAX_CHAIN;
    repeat (n) send(FN_ALLOC, 16'($urandom_range(32257, 32768)), 12'($urandom));
    repeat (3) send(FN_ALLOC, 16'($urandom_range(rem * 512 + 1, 32768)), 12'($urandom));
    if (rem > 0) send(FN_ALLOC, 16'($urandom_range((rem - 1) * 512 + 1, rem * 512)), '0);
    send(FN_ALLOC, 16'd1, '0);
  endtask

  initial begin
    rsp.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      int gap;
      if (hold_len > 0) begin
        rsp.ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        rsp.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp.ready = 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    result_t got;
    string msg;
    if (!rst) begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        got.cluster = rsp.cluster;
        got.count   = rsp.count;
        got.last    = rsp.last;
        got.status  = status_t'(rsp.status);
        if (!board.check_beat(got, msg)) report(msg);
      end
      if (req.valid === 1'b1 && req.ready === 1'b1)
        board.note_request(req.func, req.size_bytes, req.start_cluster);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    req.valid         = 1'b0;
    req.func          = FN_ALLOC;
    req.size_bytes    = '0;
    req.start_cluster = '0;
    calm              = 1'b0;
    hold_len          = 0;
    errors            = 0;
    idle_cycles       = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // zero size, single clusters, rounding, longest chain, oversize requests
    send(FN_ALLOC, 16'd0, 12'hFFF);
    send(FN_ALLOC, 16'd1, 12'h000);
    send(FN_ALLOC, 16'd512, 12'h000);
    send(FN_ALLOC, 16'd513, 12'h555);
    send(FN_ALLOC, 16'd32768, 12'hAAA);
    send(FN_ALLOC, 16'd32769, 12'h000);
    send(FN_ALLOC, 16'hFFFF, 12'hFFF);
    // whole long chain, free cluster, single cluster chain
    send(FN_FREE, 16'hFFFF, 12'd4);
    send(FN_FREE, 16'd0, 12'd4095);
    send(FN_FREE, 16'h5A5A, 12'd0);
    // gapped chain, free from the middle, stale link into a newer chain
    send(FN_ALLOC, 16'd1536, 12'd0);
    send(FN_FREE, 16'd0, 12'd4);
    send(FN_ALLOC, 16'd1024, 12'd7);
    send(FN_FREE, 16'd0, 12'd0);
    send(FN_FREE, 16'd0, 12'd4);
    send(FN_FREE, 16'd0, 12'd1);
    send(FN_FREE, 16'd0, 12'd2);
    drain();

    for (int i = 0; i < 20; i++) begin
      calm = (i >= 7 && i < 13);
      send_random(40);
    end
    calm = 1'b0;
    drain();

    hold_len = 300;
    fill_table();

    for (int i = 0; i < 10; i++) send_random(60);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.due_beats.size() != 0)
      report($sformatf("%0d beats never arrived", board.due_beats.size()));
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
